### hdl/websocket_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shorthand for the concurrent checks written at the end of websocket_frame_deframer.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSDF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and constants shared by the WebSocket deframer modules.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam logic [31:0] MAX_MSG_RESET = 32'(1024 * 1024 * 32);
    localparam logic [6:0]  LEN_CODE_16   = 7'd126;
    localparam logic [6:0]  LEN_CODE_64   = 7'd127;
    localparam logic [3:0]  OP_BINARY     = 4'd2;
    localparam logic [3:0]  OP_PING       = 4'd9;
    localparam logic [3:0]  EXT_BYTES_16  = 4'd2;
    localparam logic [3:0]  EXT_BYTES_64  = 4'd8;
    localparam logic [3:0]  KEY_BYTES     = 4'd4;

    typedef enum logic [5:0] {
        PH_HEAD0   = 6'b000001,
        PH_HEAD1   = 6'b000010,
        PH_EXTLEN  = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_FAILED  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_MSG_END = 2'd1,
        KIND_PONG    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNMASKED  = 2'd1,
        ERR_TOO_LARGE = 2'd2
    } err_t;

    typedef enum logic [0:0] {
        CFG_IS_CLIENT = 1'b0,
        CFG_MAX_MSG   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic        is_client;
        logic [31:0] max_message_size;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        end_of_message;
        logic [1:0]  message_type;
        err_t        error_code;
    } result_t;

endpackage

### hdl/wsdf_parser.sv
// ----------------------------------------------------------------------------
// wsdf_parser
// Frame parse state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module wsdf_parser
    import wsdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  cfg_t       cfg,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic        frame_final_reg, frame_final_next;
    logic [3:0]  frame_kind_reg, frame_kind_next;
    logic        frame_masked_reg, frame_masked_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [63:0] payload_left_reg, payload_left_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  mask_pos_reg, mask_pos_next;
    logic [31:0] msg_len_reg, msg_len_next;
    logic [1:0]  msg_kind_reg, msg_kind_next;

    always_comb
    begin
        logic        frame_data;
        logic        do_after;
        logic [63:0] al_len;
        logic        al_masked;
        logic        do_start;
        logic [63:0] sp_len;
        logic [1:0]  sp_kind;
        logic [64:0] total;
        logic [63:0] pl_dec;
        logic        last;
        logic [7:0]  key_byte;

        phase_next        = phase_reg;
        frame_final_next  = frame_final_reg;
        frame_kind_next   = frame_kind_reg;
        frame_masked_next = frame_masked_reg;
        len_left_next     = len_left_reg;
        payload_left_next = payload_left_reg;
        mask_key_next     = mask_key_reg;
        mask_pos_next     = mask_pos_reg;
        msg_len_next      = msg_len_reg;
        msg_kind_next     = msg_kind_reg;

        res                = '0;
        res.kind           = KIND_PAYLOAD;
        res.error_code     = ERR_NONE;
        res.message_type   = msg_kind_reg;

        frame_data = (frame_kind_reg <= OP_BINARY);
        do_after   = 1'b0;
        al_len     = '0;
        al_masked  = 1'b0;
        do_start   = 1'b0;
        sp_len     = payload_left_reg;
        sp_kind    = msg_kind_reg;
        total      = '0;
        pl_dec     = payload_left_reg - 64'd1;
        last       = (pl_dec == 64'd0);

        unique case (mask_pos_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase

        unique case (phase_reg)
            PH_HEAD0:
            begin
                frame_final_next = in_byte[7];
                frame_kind_next  = in_byte[3:0];
                phase_next       = PH_HEAD1;
            end
            PH_HEAD1:
            begin
                frame_masked_next = in_byte[7];
                if (frame_data && !cfg.is_client && !in_byte[7])
                begin
                    phase_next     = PH_FAILED;
                    res.valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_UNMASKED;
                end
                else
                begin
                    if (frame_kind_reg == OP_PING)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_PONG;
                    end
                    payload_left_next = '0;
                    if (in_byte[6:0] == LEN_CODE_16)
                    begin
                        len_left_next = EXT_BYTES_16;
                        phase_next    = PH_EXTLEN;
                    end
                    else if (in_byte[6:0] == LEN_CODE_64)
                    begin
                        len_left_next = EXT_BYTES_64;
                        phase_next    = PH_EXTLEN;
                    end
                    else
                    begin
                        do_after  = 1'b1;
                        al_len    = {57'd0, in_byte[6:0]};
                        al_masked = in_byte[7];
                    end
                end
            end
            PH_EXTLEN:
            begin
                payload_left_next = {payload_left_reg[55:0], in_byte};
                len_left_next     = len_left_reg - 4'd1;
                if (len_left_next == 4'd0)
                begin
                    do_after  = 1'b1;
                    al_len    = payload_left_next;
                    al_masked = frame_masked_reg;
                end
            end
            PH_MASK:
            begin
                mask_key_next = {mask_key_reg[23:0], in_byte};
                len_left_next = len_left_reg - 4'd1;
                if (len_left_next == 4'd0)
                begin
                    do_start = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                mask_pos_next     = mask_pos_reg + 2'd1;
                payload_left_next = pl_dec;
                if (last)
                begin
                    phase_next = PH_HEAD0;
                end
                if (frame_data)
                begin
                    res.valid          = 1'b1;
                    res.kind           = KIND_PAYLOAD;
                    res.payload_byte   = in_byte ^ key_byte;
                    res.end_of_message = last && frame_final_reg;
                    if (last && frame_final_reg)
                    begin
                        msg_len_next  = '0;
                        msg_kind_next = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_FAILED;
            end
        endcase

        // Length known: size check for data frames, then mask key or header completion.
        if (do_after)
        begin
            payload_left_next = al_len;
            sp_len            = al_len;
            total             = {33'd0, msg_len_reg} + {1'b0, al_len};
            if (frame_data && (total >= {33'd0, cfg.max_message_size}))
            begin
                phase_next     = PH_FAILED;
                res.valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TOO_LARGE;
            end
            else
            begin
                if (frame_data)
                begin
                    msg_len_next = total[31:0];
                    if ((msg_kind_reg == 2'd0) && (frame_kind_reg != 4'd0))
                    begin
                        msg_kind_next = frame_kind_reg[1:0];
                    end
                end
                sp_kind       = msg_kind_next;
                mask_key_next = '0;
                if (al_masked)
                begin
                    len_left_next = KEY_BYTES;
                    phase_next    = PH_MASK;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
        end

        // Header complete: an empty frame finishes here.
        if (do_start)
        begin
            mask_pos_next = 2'd0;
            if (sp_len == 64'd0)
            begin
                phase_next = PH_HEAD0;
                if (frame_data && frame_final_reg)
                begin
                    res.valid          = 1'b1;
                    res.kind           = KIND_MSG_END;
                    res.end_of_message = 1'b1;
                    res.message_type   = sp_kind;
                    msg_len_next       = '0;
                    msg_kind_next      = '0;
                end
            end
            else
            begin
                phase_next = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEAD0;
            frame_final_reg  <= 1'b0;
            frame_kind_reg   <= '0;
            frame_masked_reg <= 1'b0;
            len_left_reg     <= '0;
            payload_left_reg <= '0;
            mask_key_reg     <= '0;
            mask_pos_reg     <= '0;
            msg_len_reg      <= '0;
            msg_kind_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            frame_final_reg  <= frame_final_next;
            frame_kind_reg   <= frame_kind_next;
            frame_masked_reg <= frame_masked_next;
            len_left_reg     <= len_left_next;
            payload_left_reg <= payload_left_next;
            mask_key_reg     <= mask_key_next;
            mask_pos_reg     <= mask_pos_next;
            msg_len_reg      <= msg_len_next;
            msg_kind_reg     <= msg_kind_next;
        end
    end

endmodule

### hdl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: header, extended length, mask key,
// unmasked payload beats, pong requests and sticky errors.
// ----------------------------------------------------------------------------
// Usage:
// Received connection bytes enter on the s_ channel, one byte per beat.
// Each byte produces zero or one result beat on the m_ channel: an unmasked
// payload byte, an empty message end, a pong request or an error. m_tlast
// marks the last byte (or the empty end marker) of a complete message.
// A result appears on m_ in the cycle after its input byte is taken.
// Throughput is one byte per clock while m_tready stays high; the single
// pass from the parse state through the 65-bit length add and compare to
// the result register sets the clock period, not the rate.
// The output register decouples the sides: s_tready stays high while the
// result register is empty or is being drained. When the receiver holds
// m_tready low with a result pending, s_tready drops until it is taken.
// Configuration (is_client, max_message_size) is written through cfg_we /
// cfg_index / cfg_data while the stream is idle.
// Reset puts the parser at the first header byte, clears the message length,
// sets server mode and a 32 MiB message limit. After an error the block
// reports it once and drops all further bytes until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] payload_byte, [9:8] error_code, rest zero
    output logic        m_tlast,    // end_of_message
    output logic [3:0]  m_tuser,    // [1:0] kind, [3:2] message_type

    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "websocket_frame_deframer_assert.svh"

    cfg_t    cfg_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    step;

    // Configuration registers; the user must write them only while the stream is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_client        <= 1'b0;
            cfg_reg.max_message_size <= MAX_MSG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_IS_CLIENT: cfg_reg.is_client        <= cfg_data[0];
                CFG_MAX_MSG:   cfg_reg.max_message_size <= cfg_data;
                default:       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // A byte is taken whenever the result register is free or drains now.
    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    wsdf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (s_tdata),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= res.valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload side of the result register carries no reset.
    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.error_code, out_reg.payload_byte};
    assign m_tlast  = out_reg.end_of_message;
    assign m_tuser  = {out_reg.message_type, out_reg.kind};

    // Only payload beats carry a data byte.
    `WSDF_ASSERT_SAME(a_byte_only_payload,
        m_tvalid && (out_reg.kind != KIND_PAYLOAD), m_tdata[7:0] == 8'd0,
        "non-payload beat carries a data byte")

    // An error code comes with an error beat and only with it.
    `WSDF_ASSERT_SAME(a_err_code_match,
        m_tvalid, (out_reg.kind == KIND_ERROR) == (out_reg.error_code != ERR_NONE),
        "error code and beat kind disagree")

    // A message end only marks payload beats or the empty end marker.
    `WSDF_ASSERT_SAME(a_last_kind,
        m_tvalid && m_tlast,
        (out_reg.kind == KIND_PAYLOAD) || (out_reg.kind == KIND_MSG_END),
        "message end on a pong or error beat")

    // Once an error beat leaves, the block stays silent.
    `WSDF_ASSERT_NEXT(a_silent_after_error,
        m_tvalid && m_tready && (out_reg.kind == KIND_ERROR), !m_tvalid,
        "result produced after an error")

endmodule
